@@ src/lud_pkg.sv @@
// ----------------------------------------------------------------------------
// lud_pkg
// Shared types, constants and helpers of the lenient UTF-8 decoder.
// ----------------------------------------------------------------------------
package lud_pkg;

    localparam int BYTE_W   = 8;
    localparam int POINT_W  = 21;
    localparam int MAX_PTS  = 3;
    localparam int COUNT_W  = $clog2(MAX_PTS + 1);
    localparam int HELD_NUM = 2;

    // Sequence length implied by a first byte
    typedef enum logic [2:0] {
        LEN_BAD = 3'd0,
        LEN_1   = 3'd1,
        LEN_2   = 3'd2,
        LEN_3   = 3'd3,
        LEN_4   = 3'd4
    } lud_len_t;

    // One result item
    typedef struct packed {
        logic [POINT_W-1:0] code_point;
        logic               last_point;
    } lud_point_t;

    // All results caused by one input beat, first result in slot 0
    typedef struct packed {
        logic [COUNT_W-1:0]        count;
        lud_point_t [MAX_PTS-1:0]  point;
    } lud_bundle_t;

    function automatic lud_len_t seq_len(input logic [BYTE_W-1:0] c);
        lud_len_t len;
        case (c) inside
            [8'h00:8'h7F]: len = LEN_1;
            [8'hC0:8'hDF]: len = LEN_2;
            [8'hE0:8'hEF]: len = LEN_3;
            [8'hF0:8'hF7]: len = LEN_4;
            default:       len = LEN_BAD;
        endcase
        return len;
    endfunction

    // A lone byte decodes to itself if ASCII, otherwise to zero
    function automatic logic [POINT_W-1:0] lone_point(input logic [BYTE_W-1:0] c);
        logic [POINT_W-1:0] cp;
        cp = '0;
        if (c[BYTE_W-1] == 1'b0) begin
            cp = {{(POINT_W-BYTE_W){1'b0}}, c};
        end
        return cp;
    endfunction

    function automatic lud_point_t mk_point(input logic [POINT_W-1:0] cp,
                                            input logic last);
        lud_point_t p;
        p.code_point = cp;
        p.last_point = last;
        return p;
    endfunction

endpackage

@@ src/lud_decode.sv @@
// ----------------------------------------------------------------------------
// lud_decode
// Sequence state registers and the single-pass decode of one input beat
// into up to three code points.
// ----------------------------------------------------------------------------
module lud_decode
    import lud_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              end_of_text,
    output lud_bundle_t       bundle
);

    typedef struct packed {
        logic [BYTE_W-1:0]                lead;
        logic [HELD_NUM-1:0][BYTE_W-1:0]  held;
        logic [1:0]                       held_count;
        logic                             seq_open;
    } lud_state_t;

    lud_state_t state_reg, state_next;

    lud_len_t   b_len;
    lud_len_t   lead_len;
    lud_len_t   x_len;
    logic       complete;
    logic [BYTE_W-1:0] tail_x;

    assign b_len    = seq_len(text_byte);
    assign lead_len = seq_len(state_reg.lead);
    assign tail_x   = state_reg.held[0];
    assign x_len    = seq_len(tail_x);

    // Does this beat close the open sequence
    always_comb begin
        case (lead_len)
            LEN_3:   complete = (state_reg.held_count != 2'd0);
            LEN_4:   complete = state_reg.held_count[1];
            default: complete = 1'b1;
        endcase
    end

    // Decode the beat against the current state
    always_comb begin
        state_next   = state_reg;
        bundle.count = '0;
        bundle.point = '0;

        if (!state_reg.seq_open) begin
            if (end_of_text) begin
                bundle.count    = COUNT_W'(1);
                bundle.point[0] = mk_point(lone_point(text_byte), 1'b1);
                state_next      = '0;
            end else if (b_len == LEN_1 || b_len == LEN_BAD) begin
                bundle.count    = COUNT_W'(1);
                bundle.point[0] = mk_point(lone_point(text_byte), 1'b0);
            end else begin
                state_next.lead       = text_byte;
                state_next.held_count = 2'd0;
                state_next.seq_open   = 1'b1;
            end
        end else if (complete) begin
            // Pack lead payload and the six low bits of each following byte
            bundle.count = COUNT_W'(1);
            case (lead_len)
                LEN_3: bundle.point[0] = mk_point({5'd0, state_reg.lead[3:0],
                    state_reg.held[0][5:0], text_byte[5:0]}, end_of_text);
                LEN_4: bundle.point[0] = mk_point({state_reg.lead[2:0],
                    state_reg.held[0][5:0], state_reg.held[1][5:0],
                    text_byte[5:0]}, end_of_text);
                default: bundle.point[0] = mk_point({10'd0, state_reg.lead[4:0],
                    text_byte[5:0]}, end_of_text);
            endcase
            state_next = '0;
        end else if (end_of_text) begin
            // Truncated lead gives zero, then redecode the bytes behind it
            bundle.point[0] = mk_point('0, 1'b0);
            if (state_reg.held_count == 2'd0) begin
                bundle.count    = COUNT_W'(2);
                bundle.point[1] = mk_point(lone_point(text_byte), 1'b1);
            end else if (x_len == LEN_2) begin
                bundle.count    = COUNT_W'(2);
                bundle.point[1] = mk_point({10'd0, tail_x[4:0], text_byte[5:0]}, 1'b1);
            end else begin
                bundle.count    = COUNT_W'(3);
                bundle.point[1] = mk_point(lone_point(tail_x), 1'b0);
                bundle.point[2] = mk_point(lone_point(text_byte), 1'b1);
            end
            state_next = '0;
        end else begin
            // Hold the following byte and wait for more
            state_next.held[state_reg.held_count[0]] = text_byte;
            state_next.held_count = state_reg.held_count + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_accept) begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/lud_emit.sv @@
// ----------------------------------------------------------------------------
// lud_emit
// Result register: holds the code points of one input beat and hands them
// out one beat at a time.
// ----------------------------------------------------------------------------
module lud_emit
    import lud_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  lud_bundle_t       bundle,
    output logic              load_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lud_point_t        head
);

    logic [COUNT_W-1:0]       count_reg, count_next;
    lud_point_t [MAX_PTS-1:0] point_reg, point_next;
    logic                     take;

    assign take       = m_tvalid && m_tready;
    assign m_tvalid   = (count_reg != '0);
    assign head       = point_reg[0];
    // Free next cycle if empty or the last result leaves now
    assign load_ready = (count_reg == '0) || (count_reg == COUNT_W'(1) && m_tready);

    // Load a new set or advance through the held one
    always_comb begin
        count_next = count_reg;
        point_next = point_reg;
        if (load) begin
            count_next = bundle.count;
            point_next = bundle.point;
        end else if (take) begin
            count_next = count_reg - COUNT_W'(1);
            for (int i = 0; i < MAX_PTS - 1; i++) begin
                point_next[i] = point_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        point_reg <= point_next;
    end

endmodule

@@ src/lenient_utf8_decoder.sv @@
// ----------------------------------------------------------------------------
// lenient_utf8_decoder
// Byte-stream UTF-8 decoder that never rejects input.
// ----------------------------------------------------------------------------
// Accepts one text byte per cycle and returns one code point per beat. A byte
// that completes a character or stands alone gives its result in the cycle
// after it is accepted, and while m_tready is high the input keeps flowing at
// one byte per cycle. Bytes that open or continue a sequence give no result.
// When the final byte (s_tlast) ends the text inside a sequence, up to three
// results follow, one per cycle while m_tready is high, and input waits for
// the first two: the result register hands out one code point per beat.
// Invalid or truncated leads give zero; continuation bytes are not checked.
module lenient_utf8_decoder
    import lud_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_tlast    // last_point
);

    lud_bundle_t bundle;
    lud_point_t  head;
    logic        in_accept;

    assign in_accept = s_tvalid && s_tready;

    lud_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .bundle      (bundle)
    );

    lud_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (in_accept),
        .bundle     (bundle),
        .load_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .head       (head)
    );

    assign m_tdata = {3'b000, head.code_point};
    assign m_tlast = head.last_point;

endmodule

@@ src/lud_checker.sv @@
// ----------------------------------------------------------------------------
// lud_checker
// Port-level checks of the lenient UTF-8 decoder.
// ----------------------------------------------------------------------------
module lud_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // Stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Input stalls only while results wait
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // Final byte always yields a result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after final byte");

    // Padding bits above the code point stay clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:21] == 3'b000)
        else $error("padding bits set in result beat");

endmodule

bind lenient_utf8_decoder lud_checker u_lud_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
